### src/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free-list slot allocator
// Field widths, command, status and register codes, payload and control
// structs used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int SLOT_W     = 10;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int INIT_W     = 10;
  localparam int CAP_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int CAP_RESET  = 1024;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   high_water;
  } out_t;

  typedef struct packed {
    logic load;
    logic idle;
    logic walk_rd;
    logic walk_step;
    logic sweep;
    logic sweep_clear;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic walk_more;
    logic sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### src/free_list_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator_core: linked free-list slot allocator
// Hands out and takes back slot numbers kept in a singly linked free list
// in a link RAM, with a per-slot valid RAM and a high-water mark.
//
// Requests enter on in_valid/in_ready (in_data: command, slot, count),
// results leave on out_valid/out_ready (out_data: granted_slot, status,
// high_water), one result per request, in order. Registers initial_count
// (index 0) and capacity (index 1) are written on cfg_valid/cfg_ready,
// which is always ready; write them only while the block is idle.
//
// After reset a clearing pass wipes the valid RAM; no request is taken
// meanwhile. Alloc and free are accepted and then run in the execute
// state, using the registered RAM read. Check walks the list one link RAM
// read at a time, up to min(count, list length) links. Init sweeps every
// RAM entry.
// A finished result waits in the output register while the next request
// is accepted; that request holds in execute until the register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_slot_allocator_core #(
  parameter int DEPTH = fla_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fla_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fla_pkg::out_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fla_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);

  fla_pkg::ctrl_t   ctrl;
  fla_pkg::dp_sts_t sts;

  logic                       link_we;
  logic [AW-1:0]              link_waddr;
  logic [fla_pkg::SLOT_W-1:0] link_wdata;
  logic [AW-1:0]              link_raddr;
  logic [fla_pkg::SLOT_W-1:0] link_rdata;
  logic                       vld_we;
  logic [AW-1:0]              vld_waddr;
  logic                       vld_wdata;
  logic [AW-1:0]              vld_raddr;
  logic                       vld_rdata;

  assign cfg_ready = 1'b1;

  fla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctrl       (ctrl),
    .sts        (sts)
  );

  fla_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctrl       (ctrl),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .vld_we     (vld_we),
    .vld_waddr  (vld_waddr),
    .vld_wdata  (vld_wdata),
    .vld_raddr  (vld_raddr),
    .vld_rdata  (vld_rdata),
    .out_data   (out_data)
  );

  fla_ram #(.WIDTH(fla_pkg::SLOT_W), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  fla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (vld_raddr),
    .rdata (vld_rdata)
  );

endmodule

`default_nettype wire

### src/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl: sequencing state machine of the slot allocator
// Runs the clearing pass, accepts requests, steps list walks and init
// sweeps, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [fla_pkg::CMD_W-1:0]  in_command,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output fla_pkg::ctrl_t                  ctrl,
  input  wire fla_pkg::dp_sts_t           sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_WSTEP = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       commit;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl.load        = accept;
    ctrl.idle        = (state_r == S_IDLE);
    ctrl.walk_rd     = (state_r == S_WALK);
    ctrl.walk_step   = (state_r == S_WSTEP);
    ctrl.sweep       = (state_r == S_CLEAR) || (state_r == S_INIT);
    ctrl.sweep_clear = (state_r == S_CLEAR);
    ctrl.commit      = commit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          priority if (in_command == fla_pkg::CMD_CHECK) state_nxt = S_WALK;
          else if (in_command == fla_pkg::CMD_INIT) state_nxt = S_INIT;
          else state_nxt = S_EXEC;
        end
      end
      S_WALK: begin
        state_nxt = sts.walk_more ? S_WSTEP : S_EXEC;
      end
      S_WSTEP: begin
        state_nxt = S_WALK;
      end
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

  a_step_returns_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WSTEP) |=> (state_r == S_WALK))
    else $error("walk step did not return to walk");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised outside execute");

  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && !commit) |=> (state_r == S_EXEC))
    else $error("stalled execute left before commit");

endmodule

`default_nettype wire

### src/fla_datapath.sv
// ----------------------------------------------------------------------------
// fla_datapath: list head, mark, config and RAM port logic
// Holds the request, the free-list head and high-water mark, the walk
// and sweep counters, and forms the result on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_datapath #(
  parameter int DEPTH = fla_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fla_pkg::in_t                    in_data,
  input  wire fla_pkg::ctrl_t                  ctrl,
  output fla_pkg::dp_sts_t                     sts,
  input  wire logic                            cfg_we,
  input  wire logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fla_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 link_we,
  output logic [AW-1:0]                        link_waddr,
  output logic [fla_pkg::SLOT_W-1:0]           link_wdata,
  output logic [AW-1:0]                        link_raddr,
  input  wire logic [fla_pkg::SLOT_W-1:0]      link_rdata,
  output logic                                 vld_we,
  output logic [AW-1:0]                        vld_waddr,
  output logic                                 vld_wdata,
  output logic [AW-1:0]                        vld_raddr,
  input  wire logic                            vld_rdata,
  output fla_pkg::out_t                        out_data
);

  localparam int SW = fla_pkg::SLOT_W;
  localparam int EW = (AW + 1 > fla_pkg::CAP_W) ? AW + 1 : fla_pkg::CAP_W;

  fla_pkg::in_t                  item_r, item_nxt;
  fla_pkg::out_t                 out_r, out_nxt;
  logic [SW-1:0]                 head_r, head_nxt;
  logic [SW-1:0]                 mark_r, mark_nxt;
  logic [SW-1:0]                 cur_r, cur_nxt;
  logic [fla_pkg::COUNT_W-1:0]   seen_r, seen_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  logic [fla_pkg::INIT_W-1:0]    init_cnt_r;
  logic [fla_pkg::CAP_W-1:0]     cap_r;

  logic [EW-1:0] cap_eff;
  logic [EW-1:0] first;
  logic [EW-1:0] k_ext;
  logic          alloc_ok;
  logic          free_ok;

  assign cap_eff  = (EW'(cap_r) < EW'(DEPTH)) ? EW'(cap_r) : EW'(DEPTH);
  assign first    = EW'(init_cnt_r) + EW'(1);
  assign k_ext    = EW'(k_r);
  assign alloc_ok = (head_r != '0) && (EW'(head_r) < EW'(DEPTH));
  assign free_ok  = (item_r.slot != '0) && (EW'(item_r.slot) < EW'(DEPTH)) && vld_rdata;

  assign sts.walk_more  = (seen_r < item_r.count) && (cur_r != '0) &&
                          (EW'(cur_r) < EW'(DEPTH)) && (EW'(seen_r) < EW'(DEPTH));
  assign sts.sweep_last = (k_r == AW'(DEPTH - 1));

  assign link_raddr = ctrl.walk_rd ? AW'(cur_r) : AW'(head_r);
  assign vld_raddr  = ctrl.idle ? AW'(in_data.slot) : AW'(item_r.slot);
  assign out_data   = out_r;

  always_comb begin
    item_nxt   = item_r;
    out_nxt    = out_r;
    head_nxt   = head_r;
    mark_nxt   = mark_r;
    cur_nxt    = cur_r;
    seen_nxt   = seen_r;
    k_nxt      = k_r;
    link_we    = 1'b0;
    link_waddr = k_r;
    link_wdata = '0;
    vld_we     = 1'b0;
    vld_waddr  = k_r;
    vld_wdata  = 1'b0;

    if (ctrl.load) begin
      item_nxt = in_data;
      cur_nxt  = head_r;
      seen_nxt = '0;
      k_nxt    = '0;
    end

    if (ctrl.walk_step) begin
      cur_nxt  = link_rdata;
      seen_nxt = seen_r + fla_pkg::COUNT_W'(1);
    end

    if (ctrl.sweep) begin
      vld_we     = 1'b1;
      vld_wdata  = !ctrl.sweep_clear && (k_r != '0) && (k_ext <= EW'(init_cnt_r));
      link_we    = !ctrl.sweep_clear && (k_ext >= first) && (k_ext < cap_eff);
      link_wdata = (k_ext + EW'(1) == cap_eff) ? '0 : SW'(k_ext + EW'(1));
      k_nxt      = sts.sweep_last ? '0 : k_r + AW'(1);
    end

    if (ctrl.commit) begin
      out_nxt.granted_slot = '0;
      out_nxt.status       = fla_pkg::ST_OK;
      unique case (item_r.command)
        fla_pkg::CMD_ALLOC: begin
          if (alloc_ok) begin
            if (head_r > mark_r) mark_nxt = head_r;
            head_nxt             = link_rdata;
            link_we              = 1'b1;
            link_waddr           = AW'(head_r);
            link_wdata           = '0;
            vld_we               = 1'b1;
            vld_waddr            = AW'(head_r);
            vld_wdata            = 1'b1;
            out_nxt.granted_slot = head_r;
          end else begin
            out_nxt.status = fla_pkg::ST_EMPTY;
          end
        end
        fla_pkg::CMD_FREE: begin
          if (free_ok) begin
            vld_we     = 1'b1;
            vld_waddr  = AW'(item_r.slot);
            vld_wdata  = 1'b0;
            link_we    = 1'b1;
            link_waddr = AW'(item_r.slot);
            link_wdata = head_r;
            head_nxt   = item_r.slot;
            if (item_r.slot == mark_r) mark_nxt = mark_r - SW'(1);
          end else begin
            out_nxt.status = fla_pkg::ST_INVALID;
          end
        end
        fla_pkg::CMD_CHECK: begin
          out_nxt.status = (seen_r >= item_r.count) ? fla_pkg::ST_OK : fla_pkg::ST_EMPTY;
        end
        fla_pkg::CMD_INIT: begin
          head_nxt = (first < cap_eff) ? SW'(first) : '0;
          mark_nxt = SW'(init_cnt_r);
        end
        default: begin
          out_nxt.status = fla_pkg::ST_OK;
        end
      endcase
      out_nxt.high_water = mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      mark_r     <= '0;
      k_r        <= '0;
      init_cnt_r <= '0;
      cap_r      <= fla_pkg::CAP_W'(fla_pkg::CAP_RESET);
    end else begin
      head_r <= head_nxt;
      mark_r <= mark_nxt;
      k_r    <= k_nxt;
      if (cfg_we && (cfg_index == fla_pkg::CFG_INITIAL_COUNT)) begin
        init_cnt_r <= cfg_data[fla_pkg::INIT_W-1:0];
      end
      if (cfg_we && (cfg_index == fla_pkg::CFG_CAPACITY)) begin
        cap_r <= cfg_data[fla_pkg::CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
    cur_r  <= cur_nxt;
    seen_r <= seen_nxt;
  end

  a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.sweep && sts.sweep_last) |=> (k_r == '0))
    else $error("sweep counter did not wrap after last entry");

  a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && (item_r.command == fla_pkg::CMD_ALLOC) && alloc_ok)
      |=> (head_r == $past(link_rdata)))
    else $error("alloc did not advance the list head");

endmodule

`default_nettype wire

### tb/free_list_slot_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator_core_tb: self-checking bench for the slot allocator
// Drives alloc, free, check and init requests through a directed table and
// then through randomized phases under several register settings. A
// behavioral free list predicts results the table leaves open; each result
// is checked against the oldest expectation. Both handshakes idle in bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_slot_allocator_core_tb;
  import fla_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_t                    req;
    logic                   known;
    out_t                   want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [SLOT_W-1:0]      link_mem [DEPTH];
  logic                   slot_in_use [DEPTH];
  logic [SLOT_W-1:0]      head_slot = '0;
  logic [SLOT_W-1:0]      hw_mark = '0;
  logic [INIT_W-1:0]      reg_initial_count = '0;
  logic [CAP_W-1:0]       reg_capacity = CAP_W'(CAP_RESET);

  out_t                   expected_results [$];
  int                     mismatch_count = 0;
  bit                     idle_on = 1'b1;
  int                     stall_left = 0;

  free_list_slot_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      link_mem[k] = '0;
      slot_in_use[k] = 1'b0;
    end
  end

  function automatic out_t apply_command(input in_t req);
    out_t res;
    logic [SLOT_W-1:0] cur;
    int seen;
    int cap;
    int first;
    res = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        cur = head_slot;
        if (cur == '0) begin
          res.status = ST_EMPTY;
        end else begin
          if (cur > hw_mark) hw_mark = cur;
          head_slot = link_mem[cur];
          link_mem[cur] = '0;
          slot_in_use[cur] = 1'b1;
          res.granted_slot = cur;
        end
      end
      CMD_FREE: begin
        if (req.slot == '0 || !slot_in_use[req.slot]) begin
          res.status = ST_INVALID;
        end else begin
          slot_in_use[req.slot] = 1'b0;
          link_mem[req.slot] = head_slot;
          head_slot = req.slot;
          if (req.slot == hw_mark) hw_mark = hw_mark - 1'b1;
        end
      end
      CMD_CHECK: begin
        cur = head_slot;
        seen = 0;
        while (seen < int'(req.count) && cur != '0 && seen < DEPTH) begin
          seen++;
          cur = link_mem[cur];
        end
        if (seen < int'(req.count)) res.status = ST_EMPTY;
      end
      CMD_INIT: begin
        cap = (int'(reg_capacity) < DEPTH) ? int'(reg_capacity) : DEPTH;
        first = int'(reg_initial_count) + 1;
        for (int k = 0; k < DEPTH; k++) slot_in_use[k] = (k >= 1 && k < first);
        if (cap >= 2 && first <= cap - 1) begin
          for (int k = first; k < cap - 1; k++) link_mem[k] = SLOT_W'(k + 1);
          link_mem[cap - 1] = '0;
          head_slot = SLOT_W'(first);
        end else begin
          head_slot = '0;
        end
        hw_mark = reg_initial_count;
      end
    endcase
    res.high_water = hw_mark;
    return res;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_held_slot();
    int start;
    int s;
    start = $urandom_range(1, DEPTH - 1);
    for (int k = 0; k < DEPTH - 1; k++) begin
      s = 1 + (start - 1 + k) % (DEPTH - 1);
      if (slot_in_use[s]) return SLOT_W'(s);
    end
    return SLOT_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic in_t random_request();
    in_t req;
    int pick;
    int spread;
    pick = $urandom_range(0, 99);
    req.slot = SLOT_W'($urandom_range(0, DEPTH - 1));
    req.count = COUNT_W'($urandom_range(0, DEPTH));
    if (pick < 42) begin
      req.command = CMD_ALLOC;
    end else if (pick < 78) begin
      req.command = CMD_FREE;
      if ($urandom_range(0, 4) != 0) req.slot = pick_held_slot();
    end else if (pick < 98) begin
      req.command = CMD_CHECK;
      spread = $urandom_range(0, 19);
      if (spread >= 5) begin
        req.count = COUNT_W'($urandom_range(0, 8));
      end else if (spread >= 1) begin
        req.count = COUNT_W'($urandom_range(0, 64));
      end
    end else begin
      req.command = CMD_INIT;
    end
    return req;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    r.req = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t cmd_row(input logic [CMD_W-1:0] cmd, input int slot_no,
                                   input int cnt);
    row_t r;
    r.kind = ROW_REQ;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.req.command = cmd;
    r.req.slot = SLOT_W'(slot_no);
    r.req.count = COUNT_W'(cnt);
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t known_row(input logic [CMD_W-1:0] cmd, input int slot_no,
                                     input int cnt, input int granted,
                                     input logic [STATUS_W-1:0] st, input int hw);
    row_t r;
    r = cmd_row(cmd, slot_no, cnt);
    r.known = 1'b1;
    r.want.granted_slot = SLOT_W'(granted);
    r.want.status = st;
    r.want.high_water = SLOT_W'(hw);
    return r;
  endfunction

  task automatic send_request(input in_t req, input logic known, input out_t known_res);
    int gap;
    out_t predicted;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_command(req);
    expected_results.push_back(known ? known_res : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_INITIAL_COUNT) begin
      reg_initial_count = val[INIT_W-1:0];
    end else if (idx == CFG_CAPACITY) begin
      reg_capacity = val[CAP_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int ic, input int cap, input int n_items, input bit idle);
    in_t init_req;
    init_req = '0;
    init_req.command = CMD_INIT;
    write_reg(CFG_INITIAL_COUNT, CFG_DATA_W'(ic));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    idle_on = idle;
    send_request(init_req, 1'b0, '0);
    repeat (n_items) send_request(random_request(), 1'b0, '0);
  endtask

  // stall the result channel in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected slot %0d status %0d mark %0d,", what,
               want.granted_slot, want.status, want.high_water);
      $display("  got slot %0d status %0d mark %0d",
               got.granted_slot, got.status, got.high_water);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("no request outstanding", '0, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.granted_slot !== want.granted_slot ||
            out_data.status !== want.status ||
            out_data.high_water !== want.high_water) begin
          report_mismatch("result", want, out_data);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    row_t rows [$];
    rows = '{
      known_row(CMD_ALLOC, 0, 0, 0, ST_EMPTY, 0),
      known_row(CMD_FREE, 0, 0, 0, ST_INVALID, 0),
      known_row(CMD_FREE, 1023, 1024, 0, ST_INVALID, 0),
      known_row(CMD_CHECK, 0, 0, 0, ST_OK, 0),
      known_row(CMD_CHECK, 0, 1, 0, ST_EMPTY, 0),
      known_row(CMD_INIT, 0, 0, 0, ST_OK, 0),
      known_row(CMD_CHECK, 1023, 1024, 0, ST_EMPTY, 0),
      known_row(CMD_CHECK, 0, 1023, 0, ST_OK, 0),
      known_row(CMD_ALLOC, 0, 0, 1, ST_OK, 1),
      known_row(CMD_ALLOC, 0, 0, 2, ST_OK, 2),
      known_row(CMD_FREE, 2, 0, 0, ST_OK, 1),
      known_row(CMD_FREE, 2, 0, 0, ST_INVALID, 1),
      cmd_row(CMD_ALLOC, 1023, 1024),
      cmd_row(CMD_FREE, 1, 0),
      reg_row(CFG_INITIAL_COUNT, 1023),
      known_row(CMD_INIT, 0, 0, 0, ST_OK, 1023),
      known_row(CMD_ALLOC, 0, 0, 0, ST_EMPTY, 1023),
      known_row(CMD_FREE, 1023, 0, 0, ST_OK, 1022),
      known_row(CMD_ALLOC, 0, 0, 1023, ST_OK, 1023),
      reg_row(CFG_INITIAL_COUNT, 0),
      reg_row(CFG_CAPACITY, 2),
      known_row(CMD_INIT, 0, 0, 0, ST_OK, 0),
      known_row(CMD_ALLOC, 0, 0, 1, ST_OK, 1),
      known_row(CMD_ALLOC, 0, 0, 0, ST_EMPTY, 1),
      known_row(CMD_FREE, 1, 0, 0, ST_OK, 0),
      reg_row(CFG_UNMAPPED_LO, 2047),
      reg_row(CFG_UNMAPPED_HI, 2047),
      known_row(CMD_INIT, 0, 0, 0, ST_OK, 0),
      known_row(CMD_CHECK, 0, 2, 0, ST_EMPTY, 0),
      reg_row(CFG_INITIAL_COUNT, 5),
      reg_row(CFG_CAPACITY, 3),
      known_row(CMD_INIT, 0, 0, 0, ST_OK, 5),
      known_row(CMD_CHECK, 0, 1, 0, ST_EMPTY, 5),
      cmd_row(CMD_FREE, 3, 0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_request(rows[i].req, rows[i].known, rows[i].want);
      end
    end

    run_phase(0, 1024, 300, 1'b1);
    run_phase(1023, 1024, 250, 1'b1);
    run_phase($urandom_range(0, 100), $urandom_range(100, 1024), 250, 1'b0);
    run_phase(0, 2, 200, 1'b1);
    run_phase($urandom_range(0, 1023), $urandom_range(2, 1024), 250, 1'b1);
    run_phase($urandom_range(0, 200), 1024, 300, 1'b0);

    // drain outstanding results
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
